FILE: src/bxd_pkg.sv
// Shared types, constants and helper functions for the box average downscaler.
`timescale 1ns / 1ps

package bxd_pkg;

  localparam int IMAGE_SIZE  = 256;
  localparam int CNT_W       = $clog2(IMAGE_SIZE);
  localparam int LIM_W       = CNT_W + 1;
  localparam int BLK_W       = 7;
  localparam int STORE_DEPTH = 128;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int CH_W        = 12;
  localparam int SUM_W       = 3 * CH_W;
  localparam int PIX_W       = 8;

  // floor(x / 9) == (x * DIV9_MUL) >> DIV9_SHIFT for every 12-bit x
  localparam logic [CH_W-1:0] DIV9_MUL   = CH_W'(3641);
  localparam int              DIV9_SHIFT = 15;

  localparam logic [LIM_W-1:0] LIMIT_HALF    = LIM_W'((IMAGE_SIZE / 2) * 2);
  localparam logic [LIM_W-1:0] LIMIT_THIRD   = LIM_W'((IMAGE_SIZE / 3) * 3);
  localparam logic [LIM_W-1:0] LIMIT_QUARTER = LIM_W'((IMAGE_SIZE / 4) * 4);
  localparam logic [CNT_W-1:0] LAST_POS      = CNT_W'(IMAGE_SIZE - 1);

  typedef enum logic [1:0] {
    SHRINK_HALF    = 2'd0,
    SHRINK_THIRD   = 2'd1,
    SHRINK_QUARTER = 2'd2
  } shrink_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             start_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] avg_red;
    logic [PIX_W-1:0] avg_green;
    logic [PIX_W-1:0] avg_blue;
    logic [6:0]       out_row;
    logic [6:0]       out_col;
    logic             last_of_frame;
  } pix_out_t;

  // Where the accepted pixel lands and what it causes.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              in_range;
    logic              first;
    logic              emit;
    logic              last;
    logic [BLK_W-1:0]  blk_row;
    logic [BLK_W-1:0]  blk_col;
    logic [1:0]        factor;
  } pos_info_t;

  function automatic logic [LIM_W-1:0] box_limit(input logic [1:0] factor);
    logic [LIM_W-1:0] lim;
    case (factor)
      SHRINK_HALF:  lim = LIMIT_HALF;
      SHRINK_THIRD: lim = LIMIT_THIRD;
      default:      lim = LIMIT_QUARTER;
    endcase
    return lim;
  endfunction

  // Last phase inside a block (side minus one).
  function automatic logic [1:0] box_last(input logic [1:0] factor);
    logic [1:0] ph;
    case (factor)
      SHRINK_HALF:  ph = 2'd1;
      SHRINK_THIRD: ph = 2'd2;
      default:      ph = 2'd3;
    endcase
    return ph;
  endfunction

  // Truncated block average, saturated to 8 bits.
  function automatic logic [PIX_W-1:0] box_average(input logic [CH_W-1:0] sum,
                                                   input logic [1:0]      factor);
    logic [2*CH_W-1:0] prod;
    logic [CH_W-1:0]   quo;
    prod = {{CH_W{1'b0}}, sum} * {{CH_W{1'b0}}, DIV9_MUL};
    case (factor)
      SHRINK_HALF:  quo = sum >> 2;
      SHRINK_THIRD: quo = CH_W'(prod >> DIV9_SHIFT);
      default:      quo = sum >> 4;
    endcase
    if (quo > CH_W'(255)) begin
      return PIX_W'(255);
    end
    return quo[PIX_W-1:0];
  endfunction

endpackage

FILE: src/bxd_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module bxd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bxd_position.sv
// Pixel and block position counters for the raster scan.
`timescale 1ns / 1ps

module bxd_position (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              sof_i,
  input  logic [1:0]        factor_i,
  output bxd_pkg::pos_info_t info_o
);

  import bxd_pkg::*;

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [1:0]       hph_q, hph_d, vph_q, vph_d;
  logic [BLK_W-1:0] bcol_q, bcol_d, brow_q, brow_d;

  logic [CNT_W-1:0] col, row;
  logic [1:0]       hph, vph, last_ph;
  logic [BLK_W-1:0] bcol, brow;
  logic [LIM_W-1:0] limit;
  logic             col_ok, row_ok;

  always_comb begin
    // start of frame clears the position before this pixel is placed
    col  = sof_i ? '0 : col_q;
    row  = sof_i ? '0 : row_q;
    hph  = sof_i ? '0 : hph_q;
    vph  = sof_i ? '0 : vph_q;
    bcol = sof_i ? '0 : bcol_q;
    brow = sof_i ? '0 : brow_q;

    limit   = box_limit(factor_i);
    last_ph = box_last(factor_i);
    col_ok  = {1'b0, col} < limit;
    row_ok  = {1'b0, row} < limit;

    info_o.slot     = bcol[SLOT_W-1:0];
    info_o.in_range = col_ok && row_ok;
    info_o.first    = (hph == 2'd0) && (vph == 2'd0);
    info_o.emit     = col_ok && row_ok && (hph >= last_ph) && (vph >= last_ph);
    info_o.last     = (({1'b0, row} + LIM_W'(1)) == limit) &&
                      (({1'b0, col} + LIM_W'(1)) == limit);
    info_o.blk_row  = brow;
    info_o.blk_col  = bcol;
    info_o.factor   = factor_i;
  end

  always_comb begin
    col_d  = col;
    row_d  = row;
    hph_d  = hph;
    vph_d  = vph;
    bcol_d = bcol;
    brow_d = brow;
    if (col == LAST_POS) begin
      col_d  = '0;
      hph_d  = '0;
      bcol_d = '0;
      if (row == LAST_POS) begin
        row_d  = '0;
        vph_d  = '0;
        brow_d = '0;
      end else begin
        row_d = row + CNT_W'(1);
        if (vph >= last_ph) begin
          vph_d  = '0;
          brow_d = brow + BLK_W'(1);
        end else begin
          vph_d = vph + 2'd1;
        end
      end
    end else begin
      col_d = col + CNT_W'(1);
      if (hph >= last_ph) begin
        hph_d  = '0;
        bcol_d = bcol + BLK_W'(1);
      end else begin
        hph_d = hph + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      hph_q  <= '0;
      vph_q  <= '0;
      bcol_q <= '0;
      brow_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      hph_q  <= hph_d;
      vph_q  <= vph_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
    end
  end

endmodule

FILE: src/bxd_accum.sv
// Accumulate stage with line store forwarding, averaging and the result register.
`timescale 1ns / 1ps

module bxd_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  bxd_pkg::pos_info_t          info_i,
  input  bxd_pkg::pix_in_t            pix_i,
  input  logic [bxd_pkg::SUM_W-1:0]   rdata_i,
  input  logic                        out_stall_i,
  output logic                        in_stall_o,
  output logic                        we_o,
  output logic [bxd_pkg::SLOT_W-1:0]  waddr_o,
  output logic [bxd_pkg::SUM_W-1:0]   wdata_o,
  output logic                        out_valid_o,
  output bxd_pkg::pix_out_t           out_data_o
);

  import bxd_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  pos_info_t        s1_info_q;
  pix_in_t          s1_pix_q;
  logic             fwd_hit_q, fwd_hit_d;
  logic [SUM_W-1:0] fwd_data_q;
  logic             out_valid_q, out_valid_d;
  pix_out_t         out_data_q;

  logic             out_free, s1_go;
  logic [SUM_W-1:0] prev_all, new_all;
  logic [CH_W-1:0]  sum_r, sum_g, sum_b;

  always_comb begin
    // the previous item writes the line store at the edge this one reads it
    prev_all = fwd_hit_q ? fwd_data_q : rdata_i;
    if (s1_info_q.first) begin
      prev_all = '0;
    end
    sum_r   = prev_all[CH_W-1:0]        + CH_W'(s1_pix_q.red);
    sum_g   = prev_all[2*CH_W-1:CH_W]   + CH_W'(s1_pix_q.green);
    sum_b   = prev_all[3*CH_W-1:2*CH_W] + CH_W'(s1_pix_q.blue);
    new_all = {sum_b, sum_g, sum_r};
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_info_q.emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;

  assign we_o    = s1_go && s1_info_q.in_range;
  assign waddr_o = s1_info_q.slot;
  assign wdata_o = new_all;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    fwd_hit_d = fwd_hit_q;
    if (accept_i) begin
      fwd_hit_d = we_o && (s1_info_q.slot == info_i.slot);
    end
    out_valid_d = out_valid_q;
    if (s1_go && s1_info_q.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      fwd_hit_q   <= fwd_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_info_q  <= info_i;
      s1_pix_q   <= pix_i;
      fwd_data_q <= new_all;
    end
    if (s1_go && s1_info_q.emit) begin
      out_data_q.avg_red       <= box_average(sum_r, s1_info_q.factor);
      out_data_q.avg_green     <= box_average(sum_g, s1_info_q.factor);
      out_data_q.avg_blue      <= box_average(sum_b, s1_info_q.factor);
      out_data_q.out_row       <= s1_info_q.blk_row;
      out_data_q.out_col       <= s1_info_q.blk_col;
      out_data_q.last_of_frame <= s1_info_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: src/box_average_downscaler.sv
// Box average downscaler: averages RGB over 2x2, 3x3 or 4x4 blocks of a raster frame.
// A completing pixel passes from the accumulate stage register to the result register.
// Throughput: one pixel per cycle unless the output stalls; the per-block-column line store
// does one read and one write each cycle, with the previous item's sum forwarded on a same-slot read.
// Reset clears the position counters, the pipeline valids and sets the factor to 2x2.
// The line store is not cleared; the first pixel of each block overwrites its entry.
`timescale 1ns / 1ps

module box_average_downscaler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bxd_pkg::pix_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bxd_pkg::pix_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_data_i
);

  import bxd_pkg::*;

  logic             accept;
  logic [1:0]       shrink_q;
  pos_info_t        info;
  logic             ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SUM_W-1:0] ram_wdata, ram_rdata;

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shrink_q <= SHRINK_HALF;
    end else if (cfg_we_i) begin
      shrink_q <= cfg_data_i;
    end
  end

  bxd_position u_position (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sof_i    (in_data_i.start_of_frame),
    .factor_i (shrink_q),
    .info_o   (info)
  );

  bxd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (info.slot),
    .rdata_o (ram_rdata)
  );

  bxd_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .info_i      (info),
    .pix_i       (in_data_i),
    .rdata_i     (ram_rdata),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
